// ----- hdl/dirty_rect_merge_list_core_assert.svh -----
// assertion macros shared by the dirty rectangle list modules
// expects clk and rst in scope at the point of use
`ifndef DIRTY_RECT_MERGE_LIST_CORE_ASSERT_SVH
`define DIRTY_RECT_MERGE_LIST_CORE_ASSERT_SVH

// condition in this cycle implies property in the same cycle
`define DRML_ASSERT_IMPL(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// condition in this cycle implies property in the next cycle
`define DRML_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hdl/drml_pkg.sv -----
// shared types, codes and constants for the dirty rectangle list
// no dependencies
package drml_pkg;

  localparam int DEFAULT_LIST_DEPTH = 16;

  localparam int FIELD_W   = 16;
  localparam int OP_W      = 2;
  localparam int IDX_W     = 4;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 5;
  localparam int CORD_W    = 12;
  localparam int EDGE_W    = 13;
  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] DISPLAY_W_RESET = DIM_W'(320);
  localparam logic [DIM_W-1:0] DISPLAY_H_RESET = DIM_W'(240);
  localparam logic [DIM_W-1:0] DIM_MAX         = DIM_W'(4096);

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_W = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_H = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DROPPED  = 3'd0,
    ST_ABSORBED = 3'd1,
    ST_STORED   = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  // list entry held as edges: left, top, right, bottom
  typedef struct packed {
    logic [EDGE_W-1:0] y1;
    logic [EDGE_W-1:0] x1;
    logic [CORD_W-1:0] y0;
    logic [CORD_W-1:0] x0;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  typedef struct packed {
    logic latch;
    logic clip;
    logic walk;
    logic finish;
    logic rd_take;
    logic misc;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clip_drop;
    logic count_zero;
    logic walk_last;
  } dp_stat_t;

  // zero counts as one, anything above 4096 as 4096
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

// ----- hdl/drml_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module drml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/drml_ctrl.sv -----
// controller state machine for the dirty rectangle list
// depends on drml_pkg and the shared assertion macros
`include "dirty_rect_merge_list_core_assert.svh"

module drml_ctrl import drml_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] op,
  output logic            result_valid,
  input  logic            result_ready,
  input  dp_stat_t        stat,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLIP,
    S_WALK,
    S_FINISH,
    S_READ,
    S_MISC,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (op)
            OP_ADD:  state_next = S_CLIP;
            OP_READ: state_next = S_READ;
            default: state_next = S_MISC;
          endcase
        end
      end
      S_CLIP: begin
        cmd.clip = 1'b1;
        priority if (stat.clip_drop) state_next = S_RESULT;
        else if (stat.count_zero)    state_next = S_FINISH;
        else                         state_next = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_RESULT;
      end
      S_READ: begin
        cmd.rd_take = 1'b1;
        state_next  = S_RESULT;
      end
      S_MISC: begin
        cmd.misc   = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!result_valid || result_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  `DRML_ASSERT_NEXT(a_add_starts_clip, in_valid && in_ready && op == OP_ADD,
                    state == S_CLIP, "add item did not move on to clipping")
  `DRML_ASSERT_IMPL(a_load_when_free, cmd.load_out, !result_valid || result_ready,
                    "waiting result overwritten")

endmodule

// ----- hdl/drml_dp.sv -----
// datapath for the dirty rectangle list: clipping, list walk, merge and result
// depends on drml_pkg, drml_ram and the shared assertion macros
`include "dirty_rect_merge_list_core_assert.svh"

module drml_dp import drml_pkg::*; #(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [DIM_W-1:0]           cfg_data,
  input  logic [OP_W-1:0]            op,
  input  logic signed [FIELD_W-1:0]  rect_x,
  input  logic signed [FIELD_W-1:0]  rect_y,
  input  logic signed [FIELD_W-1:0]  rect_w,
  input  logic signed [FIELD_W-1:0]  rect_h,
  input  logic [IDX_W-1:0]           read_index,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  output logic [STATUS_W-1:0]        status,
  output logic [COUNT_W-1:0]         entry_count,
  output logic [COUNT_W-1:0]         merged_count,
  output logic [CORD_W-1:0]          out_x,
  output logic [CORD_W-1:0]          out_y,
  output logic [EDGE_W-1:0]          out_w,
  output logic [EDGE_W-1:0]          out_h,
  output logic                       out_valid
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int SW = FIELD_W + 1;

  logic [DIM_W-1:0] dw;
  logic [DIM_W-1:0] dh;

  logic [OP_W-1:0]           op_q;
  logic signed [FIELD_W-1:0] rx_q;
  logic signed [FIELD_W-1:0] ry_q;
  logic signed [FIELD_W-1:0] rw_q;
  logic signed [FIELD_W-1:0] rh_q;
  logic                      rd_hit;

  rect_t         n_q;
  logic [CW-1:0] count;
  logic [CW-1:0] ra;
  logic [CW-1:0] wp;
  logic [CW-1:0] merged;
  logic          absorbed;

  status_t           res_status;
  logic [CW-1:0]     res_count;
  logic [CW-1:0]     res_merged;
  logic [CORD_W-1:0] res_x;
  logic [CORD_W-1:0] res_y;
  logic [EDGE_W-1:0] res_w;
  logic [EDGE_W-1:0] res_h;
  logic              res_ok;

  // ram ports
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [RECT_W-1:0] wdata;
  logic [RECT_W-1:0] rdata;

  // clipping
  logic signed [SW-1:0] x1_raw;
  logic signed [SW-1:0] y1_raw;
  logic signed [SW-1:0] dw_s;
  logic signed [SW-1:0] dh_s;
  logic signed [SW-1:0] x0_s;
  logic signed [SW-1:0] y0_s;
  logic [CORD_W-1:0]    x0_c;
  logic [CORD_W-1:0]    y0_c;
  logic [EDGE_W-1:0]    x1_c;
  logic [EDGE_W-1:0]    y1_c;
  logic                 clip_drop;

  // walk
  rect_t e;
  rect_t n_bb;
  logic  full;
  logic  hit;
  logic  keep;
  logic  store;

  always_comb begin
    x1_raw = {rx_q[FIELD_W-1], rx_q} + {rw_q[FIELD_W-1], rw_q};
    y1_raw = {ry_q[FIELD_W-1], ry_q} + {rh_q[FIELD_W-1], rh_q};
    dw_s   = {{(SW-DIM_W){1'b0}}, dw};
    dh_s   = {{(SW-DIM_W){1'b0}}, dh};
    x0_c   = rx_q[FIELD_W-1] ? '0 : rx_q[CORD_W-1:0];
    y0_c   = ry_q[FIELD_W-1] ? '0 : ry_q[CORD_W-1:0];
    x0_s   = {{(SW-CORD_W){1'b0}}, x0_c};
    y0_s   = {{(SW-CORD_W){1'b0}}, y0_c};
    x1_c   = (x1_raw >= dw_s) ? dw : x1_raw[EDGE_W-1:0];
    y1_c   = (y1_raw >= dh_s) ? dh : y1_raw[EDGE_W-1:0];
    clip_drop = (!rx_q[FIELD_W-1] && ($signed({rx_q[FIELD_W-1], rx_q}) >= dw_s))
             || (!ry_q[FIELD_W-1] && ($signed({ry_q[FIELD_W-1], ry_q}) >= dh_s))
             || (x1_raw <= x0_s) || (y1_raw <= y0_s);
  end

  always_comb begin
    e    = rect_t'(rdata);
    full = (e.x0 == '0) && (e.y0 == '0) && (e.x1 == dw) && (e.y1 == dh);
    hit  = ({1'b0, e.x0} < n_q.x1) && ({1'b0, n_q.x0} < e.x1)
        && ({1'b0, e.y0} < n_q.y1) && ({1'b0, n_q.y0} < e.y1);
    n_bb.x0 = (e.x0 < n_q.x0) ? e.x0 : n_q.x0;
    n_bb.y0 = (e.y0 < n_q.y0) ? e.y0 : n_q.y0;
    n_bb.x1 = (e.x1 > n_q.x1) ? e.x1 : n_q.x1;
    n_bb.y1 = (e.y1 > n_q.y1) ? e.y1 : n_q.y1;
    keep  = absorbed || full || !hit;
    store = !absorbed && (wp < CW'(LIST_DEPTH));
  end

  always_comb begin
    raddr = ra[AW-1:0];
    if (cmd.latch) raddr = AW'(read_index);
    else if (cmd.clip) raddr = '0;
    we    = (cmd.walk && keep) || (cmd.finish && store);
    waddr = wp[AW-1:0];
    wdata = cmd.finish ? n_q : e;
  end

  assign stat.clip_drop  = clip_drop;
  assign stat.count_zero = (count == '0);
  assign stat.walk_last  = (ra == count);

  drml_ram #(
    .WIDTH (RECT_W),
    .DEPTH (LIST_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dw       <= DISPLAY_W_RESET;
      dh       <= DISPLAY_H_RESET;
      count    <= '0;
      ra       <= '0;
      wp       <= '0;
      merged   <= '0;
      absorbed <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_DISPLAY_W: dw <= eff_dim(cfg_data);
          CFG_DISPLAY_H: dh <= eff_dim(cfg_data);
        endcase
      end

      if (cmd.latch) begin
        op_q   <= op;
        rx_q   <= rect_x;
        ry_q   <= rect_y;
        rw_q   <= rect_w;
        rh_q   <= rect_h;
        rd_hit <= (read_index < count);
      end

      if (cmd.clip) begin
        n_q.x0   <= x0_c;
        n_q.y0   <= y0_c;
        n_q.x1   <= x1_c;
        n_q.y1   <= y1_c;
        ra       <= CW'(1);
        wp       <= '0;
        merged   <= '0;
        absorbed <= 1'b0;
        if (clip_drop) begin
          res_status <= ST_DROPPED;
          res_count  <= count;
          res_merged <= '0;
          res_x      <= '0;
          res_y      <= '0;
          res_w      <= '0;
          res_h      <= '0;
          res_ok     <= 1'b0;
        end
      end

      if (cmd.walk) begin
        ra <= ra + CW'(1);
        if (keep) begin
          wp <= wp + CW'(1);
          if (!absorbed && full) absorbed <= 1'b1;
        end else begin
          n_q    <= n_bb;
          merged <= merged + CW'(1);
        end
      end

      if (cmd.finish) begin
        res_merged <= merged;
        if (store) begin
          count      <= wp + CW'(1);
          res_count  <= wp + CW'(1);
          res_status <= ST_STORED;
          res_x      <= n_q.x0;
          res_y      <= n_q.y0;
          res_w      <= n_q.x1 - {1'b0, n_q.x0};
          res_h      <= n_q.y1 - {1'b0, n_q.y0};
          res_ok     <= 1'b1;
        end else begin
          count      <= wp;
          res_count  <= wp;
          res_status <= absorbed ? ST_ABSORBED : ST_OVERFLOW;
          res_x      <= '0;
          res_y      <= '0;
          res_w      <= '0;
          res_h      <= '0;
          res_ok     <= 1'b0;
        end
      end

      if (cmd.rd_take) begin
        res_status <= ST_DONE;
        res_count  <= count;
        res_merged <= '0;
        if (rd_hit) begin
          res_x  <= e.x0;
          res_y  <= e.y0;
          res_w  <= e.x1 - {1'b0, e.x0};
          res_h  <= e.y1 - {1'b0, e.y0};
          res_ok <= 1'b1;
        end else begin
          res_x  <= '0;
          res_y  <= '0;
          res_w  <= '0;
          res_h  <= '0;
          res_ok <= 1'b0;
        end
      end

      if (cmd.misc) begin
        res_merged <= '0;
        res_x      <= '0;
        res_y      <= '0;
        res_w      <= '0;
        res_h      <= '0;
        res_ok     <= 1'b0;
        if (op_q == OP_CLEAR) begin
          count      <= '0;
          res_count  <= '0;
          res_status <= ST_DONE;
        end else begin
          res_count  <= count;
          res_status <= ST_DROPPED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      entry_count  <= COUNT_W'(res_count);
      merged_count <= COUNT_W'(res_merged);
      out_x        <= res_x;
      out_y        <= res_y;
      out_w        <= res_w;
      out_h        <= res_h;
      out_valid    <= res_ok;
    end
  end

  `DRML_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(LIST_DEPTH),
                    "entry count beyond list depth")
  `DRML_ASSERT_IMPL(a_walk_books, cmd.walk, merged + wp + CW'(1) == ra,
                    "walk pointers out of step")

endmodule

// ----- hdl/dirty_rect_merge_list_core.sv -----
// Dirty rectangle list: keeps up to LIST_DEPTH screen regions awaiting redraw.
// Input channel (in_valid/in_ready) takes one item: add (clip, merge with each
// overlapping entry up to a full-screen one, append if room), clear, or read
// of one entry. Output channel (result_valid/result_ready) returns one item per
// input item: status, entry and merge counts, and the stored or read rectangle.
// Configuration: cfg_write with cfg_index 0 sets display width, 1 sets height;
// write only while no item is in flight.
// An add is clipped, walks every stored entry in turn through the single ram
// read port, then appends and loads its result; an add dropped by clipping,
// a read, a clear or an unknown op loads its result after its single step.
// in_ready is high only while idle, so a new item is taken only once the
// previous one has loaded its result.
// A held result does not block the next item; the block only waits at the
// point of handing over its next result while result_ready stays low.
// Reset: list empty, display 320 x 240, no result pending. The entry store
// itself is not cleared; entries beyond the count are never returned.
// depends on drml_pkg, drml_ctrl, drml_dp
module dirty_rect_merge_list_core import drml_pkg::*; #(
  parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIM_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_W-1:0]           op,
  input  logic signed [FIELD_W-1:0] rect_x,
  input  logic signed [FIELD_W-1:0] rect_y,
  input  logic signed [FIELD_W-1:0] rect_w,
  input  logic signed [FIELD_W-1:0] rect_h,
  input  logic [IDX_W-1:0]          read_index,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [STATUS_W-1:0]       status,
  output logic [COUNT_W-1:0]        entry_count,
  output logic [COUNT_W-1:0]        merged_count,
  output logic [CORD_W-1:0]         out_x,
  output logic [CORD_W-1:0]         out_y,
  output logic [EDGE_W-1:0]         out_w,
  output logic [EDGE_W-1:0]         out_h,
  output logic                      out_valid
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  drml_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  drml_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_w       (rect_w),
    .rect_h       (rect_h),
    .read_index   (read_index),
    .cmd          (cmd),
    .stat         (stat),
    .status       (status),
    .entry_count  (entry_count),
    .merged_count (merged_count),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_w        (out_w),
    .out_h        (out_h),
    .out_valid    (out_valid)
  );

endmodule

// ----- tb/dirty_rect_merge_list_checker.sv -----
// checker for dirty_rect_merge_list_core: predicts each result item from the
// accepted input items and register writes, then compares field by field
// depends on drml_pkg
module dirty_rect_merge_list_checker import drml_pkg::*; #(
  parameter int DEPTH = DEFAULT_LIST_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIM_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [OP_W-1:0]           op,
  input  logic signed [FIELD_W-1:0] rect_x,
  input  logic signed [FIELD_W-1:0] rect_y,
  input  logic signed [FIELD_W-1:0] rect_w,
  input  logic signed [FIELD_W-1:0] rect_h,
  input  logic [IDX_W-1:0]          read_index,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic [STATUS_W-1:0]       status,
  input  logic [COUNT_W-1:0]        entry_count,
  input  logic [COUNT_W-1:0]        merged_count,
  input  logic [CORD_W-1:0]         out_x,
  input  logic [CORD_W-1:0]         out_y,
  input  logic [EDGE_W-1:0]         out_w,
  input  logic [EDGE_W-1:0]         out_h,
  input  logic                      out_valid,
  output int                        pending,
  output int                        fail_count,
  output int                        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CORD_W-1:0] x;
    logic [CORD_W-1:0] y;
    logic [EDGE_W-1:0] w;
    logic [EDGE_W-1:0] h;
  } area_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] entry_count;
    logic [COUNT_W-1:0] merged_count;
    area_t              area;
    logic               hit;
  } list_reply_t;

  area_t            regions [DEPTH];
  int               region_total;
  logic [DIM_W-1:0] disp_w;
  logic [DIM_W-1:0] disp_h;
  list_reply_t      replies_due [$];

  initial begin
    pending = 0;
    fail_count = 0;
    checked = 0;
  end

  function automatic list_reply_t apply_to_list(input logic [OP_W-1:0] code,
      input logic signed [FIELD_W-1:0] px, input logic signed [FIELD_W-1:0] py,
      input logic signed [FIELD_W-1:0] pw, input logic signed [FIELD_W-1:0] ph,
      input logic [IDX_W-1:0] idx);
    list_reply_t rep;
    area_t       e;
    int          dw, dh, nx, ny, nw, nh, ex, ey, ex1, ey1, l, t, r, b, i, merged;
    logic        full_hit;
    rep = '0;
    dw = (disp_w == 0) ? 1 : (disp_w > 4096) ? 4096 : int'(disp_w);
    dh = (disp_h == 0) ? 1 : (disp_h > 4096) ? 4096 : int'(disp_h);
    if (code == OP_CLEAR) begin
      region_total = 0;
      rep.status = ST_DONE;
    end else if (code == OP_READ) begin
      rep.status = ST_DONE;
      if (idx < region_total) begin
        rep.area = regions[idx];
        rep.hit = 1'b1;
      end
    end else if (code == OP_ADD) begin
      nx = px;
      ny = py;
      nw = pw;
      nh = ph;
      if (nx < 0) begin
        nw += nx;
        nx = 0;
      end
      if (ny < 0) begin
        nh += ny;
        ny = 0;
      end
      if (nx < dw && ny < dh && nw > 0 && nh > 0) begin
        if (nx + nw >= dw) nw = dw - nx;
        if (ny + nh >= dh) nh = dh - ny;
        i = 0;
        merged = 0;
        full_hit = 1'b0;
        while (i < region_total && !full_hit) begin
          e = regions[i];
          ex = e.x;
          ey = e.y;
          ex1 = ex + int'(e.w);
          ey1 = ey + int'(e.h);
          if (ex == 0 && ey == 0 && int'(e.w) == dw && int'(e.h) == dh) begin
            full_hit = 1'b1;
          end else begin
            l = (ex > nx) ? ex : nx;
            t = (ey > ny) ? ey : ny;
            r = (ex1 < nx + nw) ? ex1 : nx + nw;
            b = (ey1 < ny + nh) ? ey1 : ny + nh;
            if (l >= r || t >= b) begin
              i++;
            end else begin
              l = (ex < nx) ? ex : nx;
              t = (ey < ny) ? ey : ny;
              r = (ex1 > nx + nw) ? ex1 : nx + nw;
              b = (ey1 > ny + nh) ? ey1 : ny + nh;
              nx = l;
              ny = t;
              nw = r - l;
              nh = b - t;
              for (int k = i; k + 1 < region_total; k++) regions[k] = regions[k + 1];
              region_total--;
              merged++;
            end
          end
        end
        rep.merged_count = COUNT_W'(merged);
        if (full_hit) begin
          rep.status = ST_ABSORBED;
        end else if (region_total >= DEPTH) begin
          rep.status = ST_OVERFLOW;
        end else begin
          e.x = CORD_W'(nx);
          e.y = CORD_W'(ny);
          e.w = EDGE_W'(nw);
          e.h = EDGE_W'(nh);
          regions[region_total] = e;
          region_total++;
          rep.status = ST_STORED;
          rep.area = e;
          rep.hit = 1'b1;
        end
      end
    end
    rep.entry_count = COUNT_W'(region_total);
    return rep;
  endfunction

  function automatic int field_differs(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    list_reply_t want;
    int          nbad, took_out;
    nbad = 0;
    took_out = 0;
    if (rst) begin
      region_total = 0;
      disp_w = DISPLAY_W_RESET;
      disp_h = DISPLAY_H_RESET;
      replies_due.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_DISPLAY_W) disp_w = cfg_data;
        else if (cfg_index == CFG_DISPLAY_H) disp_h = cfg_data;
      end
      if (result_valid && result_ready) begin
        took_out = 1;
        if (replies_due.size() == 0) begin
          $error("result item with no item outstanding");
          nbad++;
        end else begin
          want = replies_due.pop_front();
          nbad += field_differs("status", want.status, status);
          nbad += field_differs("entry_count", want.entry_count, entry_count);
          nbad += field_differs("merged_count", want.merged_count, merged_count);
          nbad += field_differs("out_x", want.area.x, out_x);
          nbad += field_differs("out_y", want.area.y, out_y);
          nbad += field_differs("out_w", want.area.w, out_w);
          nbad += field_differs("out_h", want.area.h, out_h);
          nbad += field_differs("out_valid", want.hit, out_valid);
        end
      end
      if (in_valid && in_ready) begin
        replies_due.push_back(apply_to_list(op, rect_x, rect_y, rect_w, rect_h,
                                            read_index));
      end
      pending <= replies_due.size();
      checked <= checked + took_out;
      fail_count <= fail_count + nbad;
    end
  end

endmodule

// ----- tb/tb_dirty_rect_merge_list_core.sv -----
// top of the dirty rectangle list testbench: clock, reset, stimulus, verdict
// depends on drml_pkg, dirty_rect_merge_list_core, dirty_rect_merge_list_checker
module tb_dirty_rect_merge_list_core import drml_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [DIM_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           op = '0;
  logic signed [FIELD_W-1:0] rect_x = '0;
  logic signed [FIELD_W-1:0] rect_y = '0;
  logic signed [FIELD_W-1:0] rect_w = '0;
  logic signed [FIELD_W-1:0] rect_h = '0;
  logic [IDX_W-1:0]          read_index = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        entry_count;
  logic [COUNT_W-1:0]        merged_count;
  logic [CORD_W-1:0]         out_x;
  logic [CORD_W-1:0]         out_y;
  logic [EDGE_W-1:0]         out_w;
  logic [EDGE_W-1:0]         out_h;
  logic                      out_valid;

  int pending, fail_count, checked;
  int snd_idle = 0;
  int rcv_idle = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int scr_w = 320;
  int scr_h = 240;
  int n_add = 0, n_read = 0, n_clear = 0, n_other = 0, n_settings = 1;

  always #2 clk = ~clk;

  dirty_rect_merge_list_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
    .read_index(read_index),
    .result_valid(result_valid), .result_ready(result_ready),
    .status(status), .entry_count(entry_count), .merged_count(merged_count),
    .out_x(out_x), .out_y(out_y), .out_w(out_w), .out_h(out_h),
    .out_valid(out_valid)
  );

  dirty_rect_merge_list_checker list_watch (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
    .read_index(read_index),
    .result_valid(result_valid), .result_ready(result_ready),
    .status(status), .entry_count(entry_count), .merged_count(merged_count),
    .out_x(out_x), .out_y(out_y), .out_w(out_w), .out_h(out_h),
    .out_valid(out_valid),
    .pending(pending), .fail_count(fail_count), .checked(checked)
  );

  // receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      result_ready <= 1'b0;
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] code, input int x, input int y,
                           input int w, input int h, input int idx);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= code;
    rect_x <= FIELD_W'(x);
    rect_y <= FIELD_W'(y);
    rect_w <= FIELD_W'(w);
    rect_h <= FIELD_W'(h);
    read_index <= IDX_W'(idx);
    if (code == OP_ADD) n_add++;
    else if (code == OP_READ) n_read++;
    else if (code == OP_CLEAR) n_clear++;
    else n_other++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_display(input int w, input int h);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DISPLAY_W;
    cfg_data <= DIM_W'(w);
    @(posedge clk);
    cfg_index <= CFG_DISPLAY_H;
    cfg_data <= DIM_W'(h);
    @(posedge clk);
    cfg_write <= 1'b0;
    scr_w = (w == 0) ? 1 : (w > 4096) ? 4096 : w;
    scr_h = (h == 0) ? 1 : (h > 4096) ? 4096 : h;
    n_settings++;
  endtask

  // mostly rectangles around the screen so that merges and a full list happen
  task automatic run_phase(input int count, input int hold_at, input int pause_at);
    int sel, x, y, w, h;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req <= hold_req + 1;
      if (n == pause_at) drain();
      sel = $urandom_range(0, 99);
      x = int'($urandom_range(0, 65535)) - 32768;
      y = int'($urandom_range(0, 65535)) - 32768;
      w = int'($urandom_range(0, 65535)) - 32768;
      h = int'($urandom_range(0, 65535)) - 32768;
      if (sel < 68) begin
        x = int'($urandom_range(0, scr_w + scr_w / 8)) - scr_w / 16;
        y = int'($urandom_range(0, scr_h + scr_h / 8)) - scr_h / 16;
        w = int'($urandom_range(1, scr_w / 5 + 2));
        h = int'($urandom_range(1, scr_h / 5 + 2));
        if ($urandom_range(0, 19) == 0) w = -int'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0) h = -int'($urandom_range(0, 3));
        send_item(OP_ADD, x, y, w, h, $urandom_range(0, 15));
      end else if (sel < 76) begin
        send_item(OP_ADD, x, y, w, h, $urandom_range(0, 15));
      end else if (sel < 94) begin
        send_item(OP_READ, x, y, w, h, $urandom_range(0, 15));
      end else if (sel < 96) begin
        send_item(OP_CLEAR, x, y, w, h, $urandom_range(0, 15));
      end else begin
        send_item(OP_UNUSED, x, y, w, h, $urandom_range(0, 15));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle = 9;
    rcv_idle <= 68;
    send_item(OP_READ, 0, 0, 0, 0, 15);
    send_item(OP_UNUSED, -1, -1, -1, -1, 15);
    send_item(OP_ADD, 320, 0, 10, 10, 0);
    send_item(OP_ADD, 0, 240, 10, 10, 0);
    send_item(OP_ADD, -32768, -32768, 32767, 32767, 0);
    send_item(OP_ADD, 32767, 32767, 32767, 32767, 0);
    send_item(OP_ADD, 5, 5, 0, -32768, 0);
    send_item(OP_ADD, -10, -10, 30, 30, 0);
    send_item(OP_ADD, 10, 10, 20, 20, 0);
    send_item(OP_ADD, 30, 0, 10, 10, 0);
    send_item(OP_ADD, 0, 0, 32767, 32767, 0);
    send_item(OP_ADD, 100, 100, 5, 5, 0);
    send_item(OP_READ, 0, 0, 0, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0, 0);
    for (int k = 0; k < DEFAULT_LIST_DEPTH; k++) send_item(OP_ADD, k * 20, 50, 10, 10, 0);
    send_item(OP_ADD, 0, 200, 5, 5, 0);
    send_item(OP_ADD, 5, 45, 20, 10, 0);
    send_item(OP_READ, 0, 0, 0, 0, 14);
    drain();

    run_phase(190, 80, -1);
    drain();
    set_display(4096, 4096);
    run_phase(190, -1, -1);

    drain();
    snd_idle = 68;
    rcv_idle <= 9;
    set_display(0, 0);
    run_phase(60, -1, 30);
    drain();
    set_display(8191, 1);
    run_phase(150, -1, -1);

    drain();
    snd_idle = 0;
    rcv_idle <= 0;
    set_display($urandom_range(1, 8191), $urandom_range(1, 8191));
    run_phase(170, -1, -1);
    drain();
    set_display(1, 4096);
    run_phase(140, -1, -1);

    drain();
    repeat (30) @(posedge clk);
    $display("run covered %0d adds, %0d reads, %0d clears, %0d unknown ops",
             n_add, n_read, n_clear, n_other);
    $display("over %0d display settings; %0d result items checked", n_settings, checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
